// File: design/vm16_pkg.sv
// package: payload structs, config indexes, actions, run statuses, opcodes, stop codes and sequencer states for vm16
package vm16_pkg;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         mem_address;
        logic [15:0]        word_value;
        logic signed [15:0] read_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         run_status;
        logic signed [15:0] write_value;
        logic [1:0]         io_register;
        logic [7:0]         program_counter;
        logic [15:0]        status_word;
        logic [31:0]        cycle_count;
    } out_item_t;

    localparam logic [1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [1:0] CFG_REGION_END   = 2'd1;
    localparam logic [1:0] CFG_SLICE_LENGTH = 2'd2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_SLICE = 2'd1;
    localparam logic [1:0] ACT_EXEC  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [3:0] RS_RUN   = 4'd0;
    localparam logic [3:0] RS_END   = 4'd1;
    localparam logic [3:0] RS_HALT  = 4'd2;
    localparam logic [3:0] RS_BOUND = 4'd3;
    localparam logic [3:0] RS_OVF   = 4'd4;
    localparam logic [3:0] RS_UNF   = 4'd5;
    localparam logic [3:0] RS_BAD   = 4'd6;
    localparam logic [3:0] RS_READ  = 4'd7;
    localparam logic [3:0] RS_WRITE = 4'd8;
    localparam logic [3:0] RS_SLICE = 4'd9;

    localparam logic [4:0] OP_LOAD = 5'd0;
    localparam logic [4:0] OP_STORE = 5'd1;
    localparam logic [4:0] OP_ADD = 5'd2;
    localparam logic [4:0] OP_ADDC = 5'd3;
    localparam logic [4:0] OP_SUB = 5'd4;
    localparam logic [4:0] OP_SUBC = 5'd5;
    localparam logic [4:0] OP_AND = 5'd6;
    localparam logic [4:0] OP_XOR = 5'd7;
    localparam logic [4:0] OP_COMPL = 5'd8;
    localparam logic [4:0] OP_SHL = 5'd9;
    localparam logic [4:0] OP_SHLA = 5'd10;
    localparam logic [4:0] OP_SHR = 5'd11;
    localparam logic [4:0] OP_SHRA = 5'd12;
    localparam logic [4:0] OP_COMPR = 5'd13;
    localparam logic [4:0] OP_GETSTAT = 5'd14;
    localparam logic [4:0] OP_PUTSTAT = 5'd15;
    localparam logic [4:0] OP_JUMP = 5'd16;
    localparam logic [4:0] OP_JUMPL = 5'd17;
    localparam logic [4:0] OP_JUMPE = 5'd18;
    localparam logic [4:0] OP_JUMPG = 5'd19;
    localparam logic [4:0] OP_CALL = 5'd20;
    localparam logic [4:0] OP_RETURN = 5'd21;
    localparam logic [4:0] OP_READ = 5'd22;
    localparam logic [4:0] OP_WRITE = 5'd23;
    localparam logic [4:0] OP_HALT = 5'd24;
    localparam logic [4:0] OP_NOOP = 5'd25;

    localparam logic [2:0] STOP_SLICE = 3'd0;
    localparam logic [2:0] STOP_HALT  = 3'd1;
    localparam logic [2:0] STOP_BOUND = 3'd2;
    localparam logic [2:0] STOP_OVF   = 3'd3;
    localparam logic [2:0] STOP_UNF   = 3'd4;
    localparam logic [2:0] STOP_BAD   = 3'd5;
    localparam logic [2:0] STOP_READ  = 3'd6;
    localparam logic [2:0] STOP_WRITE = 3'd7;

    localparam int unsigned FRAME_WORDS = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_MEMRD,
        ST_MEMWB,
        ST_PUSH,
        ST_POP,
        ST_POPWB,
        ST_SLICECHK,
        ST_DONE
    } state_t;

endpackage

// File: design/vm16_instruction_execute.sv
// top level: 16-bit virtual machine that executes one request per input item
// channels: s_ input requests (write word, begin slice, execute one instruction),
// m_ one result per request, cfg_ register writes (base, end, slice length).
// write-word and begin-slice requests go from fetch straight to the result.
// an instruction runs through a sequencer over one single-port word memory
// and one shared alu: fetch, decode, execute, slice check, result;
// a memory load adds a memory read and a write-back state, store writes in execute;
// call pushes six stack words one per cycle; return pops six words, each
// through a read state and a write-back state. end of program stops at
// fetch; bound, stack, bad op, halt, read and write stop after execute.
// one request is in flight at a time; s_ready is low from acceptance until the
// result is taken, so a new request is accepted in the cycle after that at best.
// the result sits in an output register until taken; while m_ready is low the
// block holds it and accepts no new request.
// reset clears registers, pc, flags, cycle count and deadline, sets the stack
// pointer to the top of memory; the word memory is not cleared and must be
// written before it is read.
module vm16_instruction_execute #(
    parameter int MEM_WORDS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  vm16_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vm16_pkg::out_item_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [8:0] MEM_TOP = 9'(MEM_WORDS);
    localparam logic [8:0] UNF_LIMIT = 9'(MEM_WORDS - vm16_pkg::FRAME_WORDS);

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rdata_reg;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wdata;

    vm16_pkg::state_t state_reg, state_next;
    vm16_pkg::in_item_t  item_reg, item_next;
    vm16_pkg::out_item_t res_reg, res_next;
    logic m_valid_reg, m_valid_next;

    logic [7:0]  base_reg;
    logic [8:0]  end_reg;
    logic [15:0] slen_reg;

    logic [15:0] rf_reg [4];
    logic [15:0] rf_next [4];
    logic [7:0]  pc_reg, pc_next;
    logic [8:0]  sp_reg, sp_next;
    logic [15:0] fl_reg, fl_next;
    logic [31:0] cyc_reg, cyc_next;
    logic [31:0] dl_reg, dl_next;
    logic [15:0] ir_reg, ir_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [3:0]  rs_reg, rs_next;
    logic [15:0] wv_reg, wv_next;
    logic [1:0]  io_reg, io_next;

    logic [4:0]  op;
    logic [1:0]  rd, rsel;
    logic        imm;
    logic [7:0]  addr;
    logic [15:0] sx, a, b, lb;
    logic [8:0]  endb, target;
    logic        tgt_bad;
    logic [16:0] alu_x, alu_y, alu_sum;
    logic        alu_sub;
    logic [31:0] cdiff;

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == vm16_pkg::ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data = res_reg;

    assign op = ir_reg[15:11];
    assign rd = ir_reg[10:9];
    assign imm = ir_reg[8];
    assign rsel = ir_reg[7:6];
    assign addr = ir_reg[7:0];
    assign sx = {{8{addr[7]}}, addr};
    assign a = rf_reg[rd];
    assign b = imm ? sx : rf_reg[rsel];
    assign lb = imm ? {8'd0, addr} : rf_reg[rsel];
    assign endb = (end_reg > 9'd256) ? 9'd256 : end_reg;
    assign target = {1'b0, base_reg} + {1'b0, addr};
    assign tgt_bad = target >= endb;
    assign alu_sub = (op == vm16_pkg::OP_SUB) || (op == vm16_pkg::OP_SUBC);
    assign alu_x = {1'b0, a};
    assign alu_y = alu_sub ? ~{1'b0, b} : {1'b0, b};
    assign cdiff = cyc_reg - dl_reg;

    always_comb begin
        logic cin;
        cin = ((op == vm16_pkg::OP_ADDC) || (op == vm16_pkg::OP_SUBC)) ? fl_reg[0] : 1'b0;
        if (alu_sub) begin
            alu_sum = alu_x + alu_y + 17'd1 - {16'd0, cin};
        end else begin
            alu_sum = alu_x + alu_y + {16'd0, cin};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vm16_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            base_reg <= 8'd0;
            end_reg <= 9'd0;
            slen_reg <= 16'd15;
            for (int i = 0; i < 4; i++) rf_reg[i] <= 16'd0;
            pc_reg <= 8'd0;
            sp_reg <= MEM_TOP;
            fl_reg <= 16'd0;
            cyc_reg <= 32'd0;
            dl_reg <= 32'd0;
            cnt_reg <= 3'd0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    vm16_pkg::CFG_REGION_BASE:  base_reg <= cfg_data[7:0];
                    vm16_pkg::CFG_REGION_END:   end_reg <= cfg_data[8:0];
                    vm16_pkg::CFG_SLICE_LENGTH: slen_reg <= cfg_data;
                    default: ;
                endcase
            end
            for (int i = 0; i < 4; i++) rf_reg[i] <= rf_next[i];
            pc_reg <= pc_next;
            sp_reg <= sp_next;
            fl_reg <= fl_next;
            cyc_reg <= cyc_next;
            dl_reg <= dl_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg <= res_next;
        ir_reg <= ir_next;
        rs_reg <= rs_next;
        wv_reg <= wv_next;
        io_reg <= io_next;
    end

    always_comb begin
        logic [15:0] push_w;
        state_next = state_reg;
        m_valid_next = m_valid_reg;
        item_next = item_reg;
        res_next = res_reg;
        for (int i = 0; i < 4; i++) rf_next[i] = rf_reg[i];
        pc_next = pc_reg;
        sp_next = sp_reg;
        fl_next = fl_reg;
        cyc_next = cyc_reg;
        dl_next = dl_reg;
        ir_next = ir_reg;
        cnt_next = cnt_reg;
        rs_next = rs_reg;
        wv_next = wv_reg;
        io_next = io_reg;
        mem_we = 1'b0;
        mem_addr = AW'(pc_reg);
        mem_wdata = a;
        push_w = 16'd0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            vm16_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    rs_next = vm16_pkg::RS_RUN;
                    wv_next = 16'd0;
                    io_next = 2'd0;
                    state_next = vm16_pkg::ST_FETCH;
                end
            end
            vm16_pkg::ST_FETCH: begin
                state_next = vm16_pkg::ST_DONE;
                case (item_reg.action)
                    vm16_pkg::ACT_WRITE: begin
                        mem_we = 1'b1;
                        mem_addr = AW'(item_reg.mem_address);
                        mem_wdata = item_reg.word_value;
                    end
                    vm16_pkg::ACT_SLICE: begin
                        dl_next = cyc_reg + {16'd0, slen_reg};
                        pc_next = item_reg.mem_address;
                        fl_next = fl_reg & 16'h001f;
                    end
                    vm16_pkg::ACT_EXEC: begin
                        if ({1'b0, pc_reg} >= endb) begin
                            rs_next = vm16_pkg::RS_END;
                        end else begin
                            mem_addr = AW'(pc_reg);
                            pc_next = pc_reg + 8'd1;
                            cyc_next = cyc_reg + 32'd1;
                            state_next = vm16_pkg::ST_DECODE;
                        end
                    end
                    default: ;
                endcase
            end
            vm16_pkg::ST_DECODE: begin
                ir_next = rdata_reg;
                state_next = vm16_pkg::ST_EXEC;
            end
            vm16_pkg::ST_EXEC: begin
                state_next = vm16_pkg::ST_SLICECHK;
                case (op)
                    vm16_pkg::OP_LOAD: begin
                        if (imm) begin
                            rf_next[rd] = sx;
                        end else if (tgt_bad) begin
                            fl_next[7:5] = vm16_pkg::STOP_BOUND;
                            rs_next = vm16_pkg::RS_BOUND;
                            state_next = vm16_pkg::ST_DONE;
                        end else begin
                            mem_addr = AW'(target);
                            cyc_next = cyc_reg + 32'd3;
                            state_next = vm16_pkg::ST_MEMRD;
                        end
                    end
                    vm16_pkg::OP_STORE: begin
                        if (tgt_bad) begin
                            fl_next[7:5] = vm16_pkg::STOP_BOUND;
                            rs_next = vm16_pkg::RS_BOUND;
                            state_next = vm16_pkg::ST_DONE;
                        end else begin
                            mem_we = 1'b1;
                            mem_addr = AW'(target);
                            mem_wdata = a;
                            cyc_next = cyc_reg + 32'd3;
                        end
                    end
                    vm16_pkg::OP_ADD, vm16_pkg::OP_ADDC: begin
                        rf_next[rd] = alu_sum[15:0];
                        fl_next[0] = alu_sum[16];
                        fl_next[4] = ~(a[15] ^ b[15]) & (a[15] ^ alu_sum[15]);
                    end
                    vm16_pkg::OP_SUB, vm16_pkg::OP_SUBC: begin
                        rf_next[rd] = alu_sum[15:0];
                        fl_next[0] = alu_sum[16];
                        fl_next[4] = (a[15] ^ b[15]) & (a[15] ^ alu_sum[15]);
                    end
                    vm16_pkg::OP_AND: rf_next[rd] = a & lb;
                    vm16_pkg::OP_XOR: rf_next[rd] = a ^ lb;
                    vm16_pkg::OP_COMPL: rf_next[rd] = ~a;
                    vm16_pkg::OP_SHL: begin
                        fl_next[0] = a[15];
                        rf_next[rd] = {a[14:0], 1'b0};
                    end
                    vm16_pkg::OP_SHLA: begin
                        fl_next[0] = a[15];
                        rf_next[rd] = {a[15], a[13:0], 1'b0};
                    end
                    vm16_pkg::OP_SHR: begin
                        fl_next[0] = a[0];
                        rf_next[rd] = {1'b0, a[15:1]};
                    end
                    vm16_pkg::OP_SHRA: begin
                        fl_next[0] = a[0];
                        rf_next[rd] = {a[15], a[15:1]};
                    end
                    vm16_pkg::OP_COMPR: begin
                        fl_next = fl_reg & 16'h0011;
                        if ($signed(a) < $signed(b)) fl_next[3] = 1'b1;
                        else if (a == b) fl_next[2] = 1'b1;
                        else fl_next[1] = 1'b1;
                    end
                    vm16_pkg::OP_GETSTAT: rf_next[rd] = fl_reg;
                    vm16_pkg::OP_PUTSTAT: fl_next = a;
                    vm16_pkg::OP_JUMP, vm16_pkg::OP_JUMPL,
                    vm16_pkg::OP_JUMPE, vm16_pkg::OP_JUMPG: begin
                        logic cond;
                        cond = (op == vm16_pkg::OP_JUMP) ? 1'b1 :
                               (op == vm16_pkg::OP_JUMPL) ? fl_reg[3] :
                               (op == vm16_pkg::OP_JUMPE) ? fl_reg[2] : fl_reg[1];
                        if (tgt_bad) begin
                            fl_next[7:5] = vm16_pkg::STOP_BOUND;
                            rs_next = vm16_pkg::RS_BOUND;
                            state_next = vm16_pkg::ST_DONE;
                        end else if (cond) begin
                            pc_next = target[7:0];
                        end
                    end
                    vm16_pkg::OP_CALL: begin
                        if (tgt_bad) begin
                            fl_next[7:5] = vm16_pkg::STOP_BOUND;
                            rs_next = vm16_pkg::RS_BOUND;
                            state_next = vm16_pkg::ST_DONE;
                        end else if ({1'b0, sp_reg} < {1'b0, endb} + 10'd6) begin
                            fl_next[7:5] = vm16_pkg::STOP_OVF;
                            rs_next = vm16_pkg::RS_OVF;
                            state_next = vm16_pkg::ST_DONE;
                        end else begin
                            cnt_next = 3'd0;
                            cyc_next = cyc_reg + 32'd3;
                            state_next = vm16_pkg::ST_PUSH;
                        end
                    end
                    vm16_pkg::OP_RETURN: begin
                        if (sp_reg > UNF_LIMIT) begin
                            fl_next[7:5] = vm16_pkg::STOP_UNF;
                            rs_next = vm16_pkg::RS_UNF;
                            state_next = vm16_pkg::ST_DONE;
                        end else begin
                            cnt_next = 3'd0;
                            mem_addr = AW'(sp_reg);
                            sp_next = sp_reg + 9'd1;
                            cyc_next = cyc_reg + 32'd3;
                            state_next = vm16_pkg::ST_POP;
                        end
                    end
                    vm16_pkg::OP_READ: begin
                        rf_next[rd] = item_reg.read_value;
                        fl_next = (fl_reg & 16'hf01f) | 16'h00c0 | {6'd0, rd, 8'd0};
                        io_next = rd;
                        rs_next = vm16_pkg::RS_READ;
                        state_next = vm16_pkg::ST_DONE;
                    end
                    vm16_pkg::OP_WRITE: begin
                        wv_next = a;
                        fl_next = (fl_reg & 16'hf01f) | 16'h00e0 | {6'd0, rd, 8'd0};
                        io_next = rd;
                        rs_next = vm16_pkg::RS_WRITE;
                        state_next = vm16_pkg::ST_DONE;
                    end
                    vm16_pkg::OP_HALT: begin
                        fl_next[7:5] = vm16_pkg::STOP_HALT;
                        rs_next = vm16_pkg::RS_HALT;
                        state_next = vm16_pkg::ST_DONE;
                    end
                    vm16_pkg::OP_NOOP: ;
                    default: begin
                        fl_next[7:5] = vm16_pkg::STOP_BAD;
                        rs_next = vm16_pkg::RS_BAD;
                        state_next = vm16_pkg::ST_DONE;
                    end
                endcase
            end
            vm16_pkg::ST_MEMRD: begin
                mem_addr = AW'(target);
                state_next = vm16_pkg::ST_MEMWB;
            end
            vm16_pkg::ST_MEMWB: begin
                rf_next[rd] = rdata_reg;
                state_next = vm16_pkg::ST_SLICECHK;
            end
            vm16_pkg::ST_PUSH: begin
                case (cnt_reg)
                    3'd0: push_w = {8'd0, pc_reg};
                    3'd1: push_w = rf_reg[0];
                    3'd2: push_w = rf_reg[1];
                    3'd3: push_w = rf_reg[2];
                    3'd4: push_w = rf_reg[3];
                    default: push_w = fl_reg;
                endcase
                mem_we = 1'b1;
                mem_addr = AW'(sp_reg - 9'd1);
                mem_wdata = push_w;
                sp_next = sp_reg - 9'd1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    pc_next = target[7:0];
                    state_next = vm16_pkg::ST_SLICECHK;
                end
            end
            vm16_pkg::ST_POP: begin
                mem_addr = AW'(sp_reg - 9'd1);
                state_next = vm16_pkg::ST_POPWB;
            end
            vm16_pkg::ST_POPWB: begin
                case (cnt_reg)
                    3'd0: fl_next = rdata_reg;
                    3'd1: rf_next[3] = rdata_reg;
                    3'd2: rf_next[2] = rdata_reg;
                    3'd3: rf_next[1] = rdata_reg;
                    3'd4: rf_next[0] = rdata_reg;
                    default: pc_next = rdata_reg[7:0];
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    state_next = vm16_pkg::ST_SLICECHK;
                end else begin
                    mem_addr = AW'(sp_reg);
                    sp_next = sp_reg + 9'd1;
                    state_next = vm16_pkg::ST_POP;
                end
            end
            vm16_pkg::ST_SLICECHK: begin
                if (!cdiff[31]) begin
                    fl_next[7:5] = vm16_pkg::STOP_SLICE;
                    rs_next = vm16_pkg::RS_SLICE;
                end
                state_next = vm16_pkg::ST_DONE;
            end
            vm16_pkg::ST_DONE: begin
                res_next.run_status = rs_reg;
                res_next.write_value = wv_reg;
                res_next.io_register = io_reg;
                res_next.program_counter = pc_reg;
                res_next.status_word = fl_reg;
                res_next.cycle_count = cyc_reg;
                m_valid_next = 1'b1;
                state_next = vm16_pkg::ST_IDLE;
            end
            default: state_next = vm16_pkg::ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == vm16_pkg::ST_IDLE) && !m_valid_reg)
        else $error("ready outside idle");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vm16_pkg::ST_DONE) |=> m_valid_reg)
        else $error("result not raised");
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= MEM_TOP)
        else $error("stack pointer out of range");
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == vm16_pkg::ST_FETCH))
        else $error("accepted request not started");
`endif

endmodule

// File: tb/sv/vm16_instruction_execute_tb.sv
// testbench: vm16 instruction execute checked request by request against a behavioral predictor
`timescale 1ns / 100ps

module vm16_instruction_execute_tb;

    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct {
        vm16_pkg::in_item_t  req;
        bit                  typed;
        vm16_pkg::out_item_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    vm16_pkg::in_item_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    vm16_pkg::out_item_t m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // machine copy
    logic [15:0] vm_mem [256];
    logic [15:0] vm_reg [4];
    logic [7:0]  vm_pc;
    logic [8:0]  vm_sp;
    logic [15:0] vm_flags;
    logic [31:0] vm_cycles;
    logic [31:0] vm_deadline;
    logic [7:0]  vm_base;
    logic [8:0]  vm_end;
    logic [15:0] vm_slen;

    vm16_pkg::out_item_t pending_results [$];
    dir_row_t    dir_rows [$];
    int          errors = 0;
    int unsigned cyc = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;

    vm16_instruction_execute DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [15:0] mk(logic [4:0] op, logic [1:0] rd, logic imm,
                                       logic [7:0] lo);
        return {op, rd, imm, lo};
    endfunction

    function automatic int unsigned end_lim();
        return (vm_end > 9'd256) ? 256 : int'(vm_end);
    endfunction

    function automatic logic [15:0] rand_instr();
        logic [4:0] op;
        op = ($urandom_range(0, 99) < 92) ? 5'($urandom_range(0, 25))
                                          : 5'($urandom_range(26, 31));
        return mk(op, 2'($urandom), 1'($urandom), 8'($urandom));
    endfunction

    task automatic push_word(logic [15:0] v);
        vm_sp = vm_sp - 9'd1;
        vm_mem[vm_sp[7:0]] = v;
    endtask

    task automatic pop_word(output logic [15:0] v);
        v = vm_mem[vm_sp[7:0]];
        vm_sp = vm_sp + 9'd1;
    endtask

    task automatic run_instr(input logic [15:0] rin, output logic [3:0] st,
                             output logic [15:0] wv, output logic [1:0] io);
        int unsigned lim;
        int unsigned tgt;
        logic [15:0] ir, a, b, sx, res, w;
        logic [4:0]  op;
        logic [1:0]  rd;
        logic        imm, cin, cond;
        logic [16:0] t;
        st = vm16_pkg::RS_RUN;
        wv = '0;
        io = '0;
        lim = end_lim();
        if (vm_pc >= lim) begin
            st = vm16_pkg::RS_END;
            return;
        end
        ir = vm_mem[vm_pc];
        vm_pc = vm_pc + 8'd1;
        op = ir[15:11];
        rd = ir[10:9];
        imm = ir[8];
        sx = {{8{ir[7]}}, ir[7:0]};
        a = vm_reg[rd];
        b = imm ? sx : vm_reg[ir[7:6]];
        tgt = vm_base + ir[7:0];
        vm_cycles = vm_cycles + 1;
        case (op)
            vm16_pkg::OP_LOAD: begin
                if (imm) begin
                    vm_reg[rd] = sx;
                end else begin
                    if (tgt >= lim) begin
                        vm_flags[7:5] = vm16_pkg::STOP_BOUND;
                        st = vm16_pkg::RS_BOUND;
                        return;
                    end
                    vm_reg[rd] = vm_mem[tgt % 256];
                    vm_cycles = vm_cycles + 3;
                end
            end
            vm16_pkg::OP_STORE: begin
                if (tgt >= lim) begin
                    vm_flags[7:5] = vm16_pkg::STOP_BOUND;
                    st = vm16_pkg::RS_BOUND;
                    return;
                end
                vm_mem[tgt % 256] = a;
                vm_cycles = vm_cycles + 3;
            end
            vm16_pkg::OP_ADD, vm16_pkg::OP_ADDC: begin
                cin = (op == vm16_pkg::OP_ADDC) ? vm_flags[0] : 1'b0;
                t = {1'b0, a} + {1'b0, b} + {16'd0, cin};
                res = t[15:0];
                vm_flags[0] = t[16];
                vm_flags[4] = ~(a[15] ^ b[15]) & (a[15] ^ res[15]);
                vm_reg[rd] = res;
            end
            vm16_pkg::OP_SUB, vm16_pkg::OP_SUBC: begin
                cin = (op == vm16_pkg::OP_SUBC) ? vm_flags[0] : 1'b0;
                t = {1'b0, a} - {1'b0, b} - {16'd0, cin};
                res = t[15:0];
                vm_flags[0] = t[16];
                vm_flags[4] = (a[15] ^ b[15]) & (a[15] ^ res[15]);
                vm_reg[rd] = res;
            end
            vm16_pkg::OP_AND: vm_reg[rd] = a & (imm ? {8'd0, ir[7:0]} : vm_reg[ir[7:6]]);
            vm16_pkg::OP_XOR: vm_reg[rd] = a ^ (imm ? {8'd0, ir[7:0]} : vm_reg[ir[7:6]]);
            vm16_pkg::OP_COMPL: vm_reg[rd] = ~a;
            vm16_pkg::OP_SHL: begin
                vm_flags[0] = a[15];
                vm_reg[rd] = {a[14:0], 1'b0};
            end
            vm16_pkg::OP_SHLA: begin
                vm_flags[0] = a[15];
                vm_reg[rd] = {a[15], a[13:0], 1'b0};
            end
            vm16_pkg::OP_SHR: begin
                vm_flags[0] = a[0];
                vm_reg[rd] = {1'b0, a[15:1]};
            end
            vm16_pkg::OP_SHRA: begin
                vm_flags[0] = a[0];
                vm_reg[rd] = {a[15], a[15:1]};
            end
            vm16_pkg::OP_COMPR: begin
                vm_flags = vm_flags & 16'h0011;
                if ($signed(a) < $signed(b)) vm_flags[3] = 1'b1;
                else if (a == b) vm_flags[2] = 1'b1;
                else vm_flags[1] = 1'b1;
            end
            vm16_pkg::OP_GETSTAT: vm_reg[rd] = vm_flags;
            vm16_pkg::OP_PUTSTAT: vm_flags = a;
            vm16_pkg::OP_JUMP, vm16_pkg::OP_JUMPL, vm16_pkg::OP_JUMPE,
            vm16_pkg::OP_JUMPG: begin
                case (op)
                    vm16_pkg::OP_JUMP:  cond = 1'b1;
                    vm16_pkg::OP_JUMPL: cond = vm_flags[3];
                    vm16_pkg::OP_JUMPE: cond = vm_flags[2];
                    default:            cond = vm_flags[1];
                endcase
                if (tgt >= lim) begin
                    vm_flags[7:5] = vm16_pkg::STOP_BOUND;
                    st = vm16_pkg::RS_BOUND;
                    return;
                end
                if (cond) vm_pc = tgt[7:0];
            end
            vm16_pkg::OP_CALL: begin
                if (tgt >= lim) begin
                    vm_flags[7:5] = vm16_pkg::STOP_BOUND;
                    st = vm16_pkg::RS_BOUND;
                    return;
                end
                if (vm_sp < lim + vm16_pkg::FRAME_WORDS) begin
                    vm_flags[7:5] = vm16_pkg::STOP_OVF;
                    st = vm16_pkg::RS_OVF;
                    return;
                end
                push_word({8'd0, vm_pc});
                for (int k = 0; k < 4; k++) push_word(vm_reg[k]);
                push_word(vm_flags);
                vm_pc = tgt[7:0];
                vm_cycles = vm_cycles + 3;
            end
            vm16_pkg::OP_RETURN: begin
                if (vm_sp > 256 - vm16_pkg::FRAME_WORDS) begin
                    vm_flags[7:5] = vm16_pkg::STOP_UNF;
                    st = vm16_pkg::RS_UNF;
                    return;
                end
                pop_word(vm_flags);
                for (int k = 3; k >= 0; k--) pop_word(vm_reg[k]);
                pop_word(w);
                vm_pc = w[7:0];
                vm_cycles = vm_cycles + 3;
            end
            vm16_pkg::OP_READ: begin
                vm_reg[rd] = rin;
                vm_flags[11:5] = {2'b00, rd, vm16_pkg::STOP_READ};
                io = rd;
                st = vm16_pkg::RS_READ;
                return;
            end
            vm16_pkg::OP_WRITE: begin
                wv = a;
                vm_flags[11:5] = {2'b00, rd, vm16_pkg::STOP_WRITE};
                io = rd;
                st = vm16_pkg::RS_WRITE;
                return;
            end
            vm16_pkg::OP_HALT: begin
                vm_flags[7:5] = vm16_pkg::STOP_HALT;
                st = vm16_pkg::RS_HALT;
                return;
            end
            vm16_pkg::OP_NOOP: ;
            default: begin
                vm_flags[7:5] = vm16_pkg::STOP_BAD;
                st = vm16_pkg::RS_BAD;
                return;
            end
        endcase
        if ((vm_cycles - vm_deadline) < 32'h80000000) begin
            vm_flags[7:5] = vm16_pkg::STOP_SLICE;
            st = vm16_pkg::RS_SLICE;
        end
    endtask

    task automatic step_machine(input vm16_pkg::in_item_t it, output vm16_pkg::out_item_t o);
        logic [3:0]  st;
        logic [15:0] wv;
        logic [1:0]  io;
        st = vm16_pkg::RS_RUN;
        wv = '0;
        io = '0;
        case (it.action)
            vm16_pkg::ACT_WRITE: vm_mem[it.mem_address] = it.word_value;
            vm16_pkg::ACT_SLICE: begin
                vm_deadline = vm_cycles + vm_slen;
                vm_pc = it.mem_address;
                vm_flags = vm_flags & 16'h001f;
            end
            vm16_pkg::ACT_EXEC: run_instr(it.read_value, st, wv, io);
            default: ;
        endcase
        o.run_status = st;
        o.write_value = wv;
        o.io_register = io;
        o.program_counter = vm_pc;
        o.status_word = vm_flags;
        o.cycle_count = vm_cycles;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cyc);
        errors++;
    endtask

    always @(posedge aclk) begin
        vm16_pkg::out_item_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result without request", m_data.run_status, 0);
                end else begin
                    w = pending_results.pop_front();
                    if (m_data.run_status !== w.run_status)
                        report_mismatch("run_status", m_data.run_status, w.run_status);
                    if (m_data.write_value !== w.write_value)
                        report_mismatch("write_value", m_data.write_value, w.write_value);
                    if (m_data.io_register !== w.io_register)
                        report_mismatch("io_register", m_data.io_register, w.io_register);
                    if (m_data.program_counter !== w.program_counter)
                        report_mismatch("program_counter", m_data.program_counter,
                                        w.program_counter);
                    if (m_data.status_word !== w.status_word)
                        report_mismatch("status_word", m_data.status_word, w.status_word);
                    if (m_data.cycle_count !== w.cycle_count)
                        report_mismatch("cycle_count", m_data.cycle_count, w.cycle_count);
                end
            end
            m_ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    task automatic send(input vm16_pkg::in_item_t it, input bit typed,
                        input vm16_pkg::out_item_t want);
        vm16_pkg::out_item_t o;
        while ($urandom_range(0, 99) < snd_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        step_machine(it, o);
        pending_results.push_back(typed ? want : o);
    endtask

    task automatic send_req(logic [1:0] act, logic [7:0] adr, logic [15:0] wd,
                            logic [15:0] rv);
        vm16_pkg::in_item_t it;
        it.action = act;
        it.mem_address = adr;
        it.word_value = wd;
        it.read_value = rv;
        send(it, 1'b0, '0);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            vm16_pkg::CFG_REGION_BASE:  vm_base = val[7:0];
            vm16_pkg::CFG_REGION_END:   vm_end = val[8:0];
            vm16_pkg::CFG_SLICE_LENGTH: vm_slen = val;
            default: ;
        endcase
    endtask

    task automatic set_region(logic [7:0] base, logic [8:0] lim, logic [15:0] slen);
        drain();
        write_cfg(vm16_pkg::CFG_REGION_BASE, {8'd0, base});
        write_cfg(vm16_pkg::CFG_REGION_END, {7'd0, lim});
        write_cfg(vm16_pkg::CFG_SLICE_LENGTH, slen);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(logic [1:0] act, logic [7:0] adr, logic [15:0] wd, logic [15:0] rv,
                           bit typed, vm16_pkg::out_item_t want);
        dir_row_t r;
        r.req.action = act;
        r.req.mem_address = adr;
        r.req.word_value = wd;
        r.req.read_value = rv;
        r.typed = typed;
        r.want = want;
        dir_rows.push_back(r);
    endtask

    task automatic random_run(int n, bit hold_off);
        int done;
        int r;
        int unsigned lim;
        done = 0;
        while (done < n) begin
            if (hold_off && done == n / 2) begin
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            r = $urandom_range(0, 99);
            lim = end_lim();
            if (r < 8) begin
                send_req(vm16_pkg::ACT_WRITE, 8'($urandom),
                         r < 4 ? rand_instr() : 16'($urandom), 16'($urandom));
                done++;
            end else if (r < 14) begin
                send_req(vm16_pkg::ACT_SLICE, (lim == 0 || r == 13) ? 8'($urandom)
                         : 8'($urandom_range(0, lim - 1)), 16'($urandom), 16'($urandom));
                done++;
            end else if (r < 16) begin
                send_req(vm16_pkg::ACT_NONE, 8'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                send_req(vm16_pkg::ACT_EXEC, 8'($urandom), 16'($urandom), 16'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        logic [15:0] prog [$];
        vm16_pkg::out_item_t z;
        foreach (vm_mem[i]) vm_mem[i] = '0;
        foreach (vm_reg[i]) vm_reg[i] = '0;
        vm_pc = '0;
        vm_sp = 9'd256;
        vm_flags = '0;
        vm_cycles = '0;
        vm_deadline = '0;
        vm_base = '0;
        vm_end = '0;
        vm_slen = 16'd15;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        snd_idle = 27;
        rcv_idle = 71;

        // reset state: empty program region, so execute ends at once
        z = '0;
        z.run_status = vm16_pkg::RS_END;
        add_row(vm16_pkg::ACT_EXEC, 8'h00, 16'h0000, 16'h0000, 1'b1, z);
        z.run_status = vm16_pkg::RS_RUN;
        add_row(vm16_pkg::ACT_NONE, 8'hff, 16'hffff, 16'hffff, 1'b1, z);
        add_row(vm16_pkg::ACT_WRITE, 8'hff, 16'hffff, 16'h0000, 1'b1, z);
        z.program_counter = 8'hff;
        add_row(vm16_pkg::ACT_SLICE, 8'hff, 16'h0000, 16'h0000, 1'b1, z);
        z.run_status = vm16_pkg::RS_END;
        add_row(vm16_pkg::ACT_EXEC, 8'h00, 16'h0000, 16'h8000, 1'b1, z);
        foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        dir_rows.delete();

        set_region(8'd0, 9'd200, 16'd40);
        prog = '{mk(vm16_pkg::OP_LOAD, 2'd0, 1'b1, 8'h80),
                 mk(vm16_pkg::OP_LOAD, 2'd1, 1'b1, 8'h7f),
                 mk(vm16_pkg::OP_ADD, 2'd0, 1'b0, 8'h40),
                 mk(vm16_pkg::OP_ADD, 2'd0, 1'b1, 8'h01),
                 mk(vm16_pkg::OP_ADDC, 2'd1, 1'b1, 8'h00),
                 mk(vm16_pkg::OP_SUB, 2'd2, 1'b1, 8'h01),
                 mk(vm16_pkg::OP_SUBC, 2'd2, 1'b1, 8'h00),
                 mk(vm16_pkg::OP_AND, 2'd2, 1'b1, 8'hff),
                 mk(vm16_pkg::OP_XOR, 2'd2, 1'b1, 8'haa),
                 mk(vm16_pkg::OP_COMPL, 2'd3, 1'b0, 8'h00),
                 mk(vm16_pkg::OP_SHLA, 2'd3, 1'b0, 8'h00),
                 mk(vm16_pkg::OP_SHRA, 2'd3, 1'b0, 8'h00),
                 mk(vm16_pkg::OP_COMPR, 2'd0, 1'b1, 8'h80),
                 mk(vm16_pkg::OP_GETSTAT, 2'd1, 1'b0, 8'h00),
                 mk(vm16_pkg::OP_STORE, 2'd2, 1'b0, 8'h90),
                 mk(vm16_pkg::OP_LOAD, 2'd3, 1'b0, 8'h90),
                 mk(vm16_pkg::OP_CALL, 2'd0, 1'b0, 8'h30),
                 mk(vm16_pkg::OP_READ, 2'd2, 1'b0, 8'h00),
                 mk(vm16_pkg::OP_WRITE, 2'd2, 1'b0, 8'h00),
                 mk(vm16_pkg::OP_JUMP, 2'd0, 1'b0, 8'hf0),
                 mk(5'd31, 2'd0, 1'b0, 8'h00),
                 mk(vm16_pkg::OP_RETURN, 2'd0, 1'b0, 8'h00),
                 mk(vm16_pkg::OP_HALT, 2'd0, 1'b0, 8'h00)};
        for (int i = 0; i < 256; i++) begin
            send_req(vm16_pkg::ACT_WRITE, 8'(i),
                     i < prog.size() ? prog[i]
                     : (i == 8'h30 ? mk(vm16_pkg::OP_RETURN, 2'd0, 1'b0, 8'h00)
                                   : rand_instr()), 16'h0000);
        end

        add_row(vm16_pkg::ACT_SLICE, 8'h00, 16'h0000, 16'h0000, 1'b0, '0);
        for (int i = 0; i < 24; i++)
            add_row(vm16_pkg::ACT_EXEC, 8'h00, 16'h0000, i[0] ? 16'h7fff : 16'h8000,
                    1'b0, '0);
        foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        random_run(230, 1'b0);

        snd_idle = 71;
        rcv_idle = 27;
        set_region(8'd255, 9'h1ff, 16'd1);
        random_run(150, 1'b0);
        set_region(8'd16, 9'd256, 16'd65535);
        random_run(190, 1'b1);

        snd_idle = 0;
        rcv_idle = 0;
        set_region(8'd0, 9'd250, 16'd7);
        random_run(190, 1'b0);

        drain();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
